// ===== rtl/gbo_pkg.sv =====
// Shared types and constants of the grid boundary outflow cell.
package gbo_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned DIV_STEPS  = 64;
    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned CNT_W      = 7;

    localparam logic [31:0] TS_RESET = 32'h0001_0000;
    localparam logic [31:0] MAX32    = 32'hFFFF_FFFF;
    localparam logic [47:0] MAX48    = 48'hFFFF_FFFF_FFFF;

    // Bit positions inside neighbour_flags.
    localparam int unsigned NB_WEST    = 0;
    localparam int unsigned NB_EAST    = 1;
    localparam int unsigned NB_NORTH   = 2;
    localparam int unsigned NB_SOUTH   = 3;
    localparam int unsigned NB_COL_INT = 4;
    localparam int unsigned NB_ROW_INT = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP = 2'd0,
        REG_EROSION   = 2'd1,
        REG_TWO_PHASE = 2'd2
    } t_reg;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SQX, OP_SQY, OP_SQSUM, OP_SQRT_GO, OP_SQRT_GET,
        OP_AREA, OP_QLO, OP_QHI, OP_QSUM, OP_DROPM, OP_DROP_GO, OP_DROP_GET,
        OP_RM1, OP_RM2, OP_RM3, OP_RM4, OP_RM5, OP_FDIV_GO, OP_FDIV_GET, OP_STOT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic phase;
    } t_cmd;

    typedef struct packed {
        logic drain;
        logic erosion_on;
        logic two_phase_on;
        logic ts_zero;
        logic iter_done;
    } t_stat;

    typedef struct packed {
        logic        start;
        logic        sqrt_mode;
        logic [63:0] x;
        logic [31:0] d;
    } t_iter_cmd;

    typedef struct packed {
        logic [31:0]        depth;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [31:0]        flow_width;
        logic [31:0]        cell_length;
        logic               is_boundary;
        logic [5:0]         neighbour_flags;
        logic [31:0]        susp_sediment;
        logic [31:0]        susp_concentration;
        logic [31:0]        bed_sediment;
        logic [31:0]        bed_concentration;
        logic               first_of_sweep;
    } t_cell;

    typedef struct packed {
        logic [31:0] new_depth;
        logic        outflowing;
        logic [31:0] cell_outflow;
        logic [31:0] new_susp_sediment;
        logic [31:0] new_bed_sediment;
        logic [31:0] cell_sediment_flux;
        logic [47:0] total_outflow;
        logic [47:0] total_sediment_flux;
    } t_res;

endpackage

// ===== rtl/gbo_if.sv =====
// Channel interfaces of the grid boundary outflow cell: cell input, result, configuration.
interface gbo_cell_if;
    logic               valid;
    logic               ready;
    logic [31:0]        depth;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [31:0]        flow_width;
    logic [31:0]        cell_length;
    logic               is_boundary;
    logic [5:0]         neighbour_flags;
    logic [31:0]        susp_sediment;
    logic [31:0]        susp_concentration;
    logic [31:0]        bed_sediment;
    logic [31:0]        bed_concentration;
    logic               first_of_sweep;

    modport source (
        output valid, depth, vel_x, vel_y, flow_width, cell_length, is_boundary,
               neighbour_flags, susp_sediment, susp_concentration, bed_sediment,
               bed_concentration, first_of_sweep,
        input  ready
    );
    modport sink (
        input  valid, depth, vel_x, vel_y, flow_width, cell_length, is_boundary,
               neighbour_flags, susp_sediment, susp_concentration, bed_sediment,
               bed_concentration, first_of_sweep,
        output ready
    );
endinterface

interface gbo_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] new_depth;
    logic        outflowing;
    logic [31:0] cell_outflow;
    logic [31:0] new_susp_sediment;
    logic [31:0] new_bed_sediment;
    logic [31:0] cell_sediment_flux;
    logic [47:0] total_outflow;
    logic [47:0] total_sediment_flux;

    modport source (
        output valid, new_depth, outflowing, cell_outflow, new_susp_sediment,
               new_bed_sediment, cell_sediment_flux, total_outflow, total_sediment_flux,
        input  ready
    );
    modport sink (
        input  valid, new_depth, outflowing, cell_outflow, new_susp_sediment,
               new_bed_sediment, cell_sediment_flux, total_outflow, total_sediment_flux,
        output ready
    );
endinterface

interface gbo_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/grid_boundary_outflow_cell_core.sv =====
// Top level of the grid boundary outflow cell: configuration, sequencer, datapath, result register.
// A cell that does not drain goes from the load via the decide state to finish. A draining cell
// runs the square root, discharge and drainage divide, and with erosion on one sediment phase (two
// in two-phase mode) and the sediment total. One new cell is taken per result: the input opens
// again once the result is loaded. The shared iterative unit retires one quotient bit (64 per
// divide) or one root bit (32 per square root) each cycle. Synchronous active-low reset clears the
// sequencer, the running totals and the result valid, and loads the configuration defaults.
module grid_boundary_outflow_cell_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gbo_cell_if.sink    i_cell,
    gbo_res_if.source   o_res,
    gbo_cfg_if.sink     i_cfg
);

    // Configuration registers. Writes are always accepted; an index past the
    // register list is dropped.
    logic [31:0] r_time_step;
    logic        r_erosion_on;
    logic        r_two_phase_on;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step    <= gbo_pkg::TS_RESET;
            r_erosion_on   <= 1'b0;
            r_two_phase_on <= 1'b0;
        end else if (i_cfg.valid) begin
            case (gbo_pkg::t_reg'(i_cfg.index))
                gbo_pkg::REG_TIME_STEP: r_time_step    <= i_cfg.data;
                gbo_pkg::REG_EROSION:   r_erosion_on   <= i_cfg.data[0];
                gbo_pkg::REG_TWO_PHASE: r_two_phase_on <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Gather the input channel into one payload word for the datapath.
    gbo_pkg::t_cell w_cell;
    always_comb begin
        w_cell.depth              = i_cell.depth;
        w_cell.vel_x              = i_cell.vel_x;
        w_cell.vel_y              = i_cell.vel_y;
        w_cell.flow_width         = i_cell.flow_width;
        w_cell.cell_length        = i_cell.cell_length;
        w_cell.is_boundary        = i_cell.is_boundary;
        w_cell.neighbour_flags    = i_cell.neighbour_flags;
        w_cell.susp_sediment      = i_cell.susp_sediment;
        w_cell.susp_concentration = i_cell.susp_concentration;
        w_cell.bed_sediment       = i_cell.bed_sediment;
        w_cell.bed_concentration  = i_cell.bed_concentration;
        w_cell.first_of_sweep     = i_cell.first_of_sweep;
    end

    gbo_pkg::t_cmd  w_cmd;
    gbo_pkg::t_stat w_stat;
    gbo_pkg::t_res  w_res;
    logic           w_in_ready;
    logic           w_out_load;
    logic           w_out_free;

    // The result register parts the sequencer from the output side: a finished
    // result moves here as soon as the slot is empty or being emptied, and the
    // sequencer goes back to take the next cell while it waits.
    gbo_pkg::t_res r_out;
    logic          r_out_valid;

    assign w_out_free = !r_out_valid || o_res.ready;

    gbo_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_cell.valid),
        .i_out_free(w_out_free),
        .i_stat    (w_stat),
        .o_in_ready(w_in_ready),
        .o_out_load(w_out_load),
        .o_cmd     (w_cmd)
    );

    gbo_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cell        (w_cell),
        .i_time_step   (r_time_step),
        .i_erosion_on  (r_erosion_on),
        .i_two_phase_on(r_two_phase_on),
        .o_stat        (w_stat),
        .o_res         (w_res)
    );

    assign i_cell.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid               = r_out_valid;
    assign o_res.new_depth           = r_out.new_depth;
    assign o_res.outflowing          = r_out.outflowing;
    assign o_res.cell_outflow        = r_out.cell_outflow;
    assign o_res.new_susp_sediment   = r_out.new_susp_sediment;
    assign o_res.new_bed_sediment    = r_out.new_bed_sediment;
    assign o_res.cell_sediment_flux  = r_out.cell_sediment_flux;
    assign o_res.total_outflow       = r_out.total_outflow;
    assign o_res.total_sediment_flux = r_out.total_sediment_flux;

    // A transfer in starts a run, so the input side closes in the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cell.valid && i_cell.ready |=> !i_cell.ready)
        else $error("input open while a cell is in work");
    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load && r_out_valid |-> o_res.ready)
        else $error("pending result overwritten");
    // A cell that did not drain reports no discharge and no sediment flux.
    a_dry_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.outflowing |->
            o_res.cell_outflow == '0 && o_res.cell_sediment_flux == '0)
        else $error("flux on a cell that did not drain");

endmodule

// ===== rtl/gbo_iter.sv =====
// Shared iterative unit: restoring divide (one bit a cycle) and integer square root.
module gbo_iter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gbo_pkg::t_iter_cmd    i_cmd,
    output logic                  o_done,
    output logic [63:0]           o_res
);

    logic [63:0]               r_x;
    logic [34:0]               r_rem;
    logic [63:0]               r_res;
    logic [31:0]               r_d;
    logic                      r_sqrt;
    logic                      r_busy;
    logic                      r_done;
    logic [gbo_pkg::CNT_W-1:0] r_cnt;

    logic [34:0] w_sh;
    logic [34:0] w_trial;
    logic        w_ge;

    always_comb begin
        if (r_sqrt) begin
            w_sh    = {r_rem[32:0], r_x[63:62]};
            w_trial = {1'b0, r_res[31:0], 2'b01};
        end else begin
            w_sh    = {2'b00, r_rem[31:0], r_x[63]};
            w_trial = {3'b000, r_d};
        end
        w_ge = (w_sh >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.sqrt_mode ? gbo_pkg::CNT_W'(gbo_pkg::SQRT_STEPS)
                                          : gbo_pkg::CNT_W'(gbo_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == gbo_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x    <= i_cmd.x;
            r_d    <= i_cmd.d;
            r_sqrt <= i_cmd.sqrt_mode;
            r_rem  <= '0;
            r_res  <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - w_trial) : w_sh;
            r_res <= {r_res[62:0], w_ge};
            r_x   <= r_sqrt ? {r_x[61:0], 2'b00} : {r_x[62:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_cmd.start) else $error("iterative unit restarted while busy");
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done raised while still busy");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt == gbo_pkg::CNT_W'(1) && !i_cmd.start |=> r_done)
        else $error("done missing after last step");

endmodule

// ===== rtl/gbo_datapath.sv =====
// Datapath: operand registers, shared multiplier, iterative unit and saturating totals.
module gbo_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gbo_pkg::t_cmd         i_cmd,
    input  gbo_pkg::t_cell        i_cell,
    input  logic [31:0]           i_time_step,
    input  logic                  i_erosion_on,
    input  logic                  i_two_phase_on,
    output gbo_pkg::t_stat        o_stat,
    output gbo_pkg::t_res         o_res
);

    logic [31:0] r_depth, r_ua, r_va, r_width, r_len;
    logic [31:0] r_ss, r_ssc, r_bl, r_blc;
    logic        r_drain;
    logic [63:0] r_p, r_a, r_b;
    logic [31:0] r_speed, r_q, r_rmv, r_ds, r_ndepth, r_sflux;
    logic [47:0] r_wtot, r_stot;

    logic [31:0]         w_ma, w_mb;
    logic [63:0]         w_prod;
    logic [64:0]         w_hsum;
    logic [31:0]         w_hsat;
    logic [31:0]         w_stock, w_take;
    logic [63:0]         w_iq;
    logic                w_idone;
    logic [31:0]         w_flux;
    logic [32:0]         w_fsum;
    logic [48:0]         w_wsum, w_ssum;
    logic                w_drain;
    logic                w_uneg, w_vneg, w_upos, w_vpos;
    gbo_pkg::t_iter_cmd  w_icmd;

    // Drain test on the incoming cell.
    always_comb begin
        w_uneg  = i_cell.vel_x[31];
        w_vneg  = i_cell.vel_y[31];
        w_upos  = !w_uneg && (|i_cell.vel_x);
        w_vpos  = !w_vneg && (|i_cell.vel_y);
        w_drain = i_cell.is_boundary && (
            (i_cell.neighbour_flags[gbo_pkg::NB_COL_INT] && (
                (i_cell.neighbour_flags[gbo_pkg::NB_WEST] &&
                 !i_cell.neighbour_flags[gbo_pkg::NB_EAST] && w_uneg) ||
                (i_cell.neighbour_flags[gbo_pkg::NB_EAST] &&
                 !i_cell.neighbour_flags[gbo_pkg::NB_WEST] && w_upos))) ||
            (i_cell.neighbour_flags[gbo_pkg::NB_ROW_INT] && (
                (i_cell.neighbour_flags[gbo_pkg::NB_NORTH] &&
                 !i_cell.neighbour_flags[gbo_pkg::NB_SOUTH] && w_vneg) ||
                (i_cell.neighbour_flags[gbo_pkg::NB_SOUTH] &&
                 !i_cell.neighbour_flags[gbo_pkg::NB_NORTH] && w_vpos))));
    end

    // Operand selection of the single 32x32 multiplier.
    always_comb begin
        case (i_cmd.op)
            gbo_pkg::OP_SQX:   begin w_ma = r_ua;         w_mb = r_ua;        end
            gbo_pkg::OP_SQY:   begin w_ma = r_va;         w_mb = r_va;        end
            gbo_pkg::OP_AREA:  begin w_ma = r_depth;      w_mb = r_width;     end
            gbo_pkg::OP_QLO:   begin w_ma = r_p[31:0];    w_mb = r_speed;     end
            gbo_pkg::OP_QHI:   begin w_ma = r_a[63:32];   w_mb = r_speed;     end
            gbo_pkg::OP_DROPM: begin w_ma = r_q;          w_mb = i_time_step; end
            gbo_pkg::OP_RM1:   begin w_ma = i_cmd.phase ? r_blc : r_ssc; w_mb = r_q; end
            gbo_pkg::OP_RM2:   begin w_ma = r_p[31:0];    w_mb = i_time_step; end
            gbo_pkg::OP_RM3:   begin w_ma = r_a[63:32];   w_mb = i_time_step; end
            default:           begin w_ma = '0;           w_mb = '0;          end
        endcase
        w_prod = {32'b0, w_ma} * {32'b0, w_mb};
    end

    // High partial product plus carried low half, saturated to 32 bits; stock take, flux and total sums.
    always_comb begin
        w_hsum  = {1'b0, r_p} + {33'b0, r_b[63:32]};
        w_hsat  = (|w_hsum[64:32]) ? gbo_pkg::MAX32 : w_hsum[31:0];
        w_stock = i_cmd.phase ? r_bl : r_ss;
        w_take  = (w_stock < r_rmv) ? w_stock : r_rmv;
        w_flux  = (|w_iq[63:32]) ? gbo_pkg::MAX32 : w_iq[31:0];
        w_fsum  = {1'b0, r_sflux} + {1'b0, w_flux};
        w_wsum  = {1'b0, r_wtot} + {17'b0, r_q};
        w_ssum  = {1'b0, r_stot} + {17'b0, r_sflux};
    end

    always_comb begin
        w_icmd = '0;
        case (i_cmd.op)
            gbo_pkg::OP_SQRT_GO: begin
                w_icmd.start     = 1'b1;
                w_icmd.sqrt_mode = 1'b1;
                w_icmd.x         = r_a;
            end
            gbo_pkg::OP_DROP_GO: begin
                w_icmd.start = 1'b1;
                w_icmd.x     = r_p;
                w_icmd.d     = (r_len == '0) ? 32'd1 : r_len;
            end
            gbo_pkg::OP_FDIV_GO: begin
                w_icmd.start = 1'b1;
                w_icmd.x     = {16'b0, r_ds, 16'b0};
                w_icmd.d     = i_time_step;
            end
            default: w_icmd = '0;
        endcase
    end

    gbo_iter u_iter (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_icmd),
        .o_done (w_idone),
        .o_res  (w_iq)
    );

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            gbo_pkg::OP_LOAD: begin
                r_depth  <= i_cell.depth;
                r_ua     <= w_uneg ? (~i_cell.vel_x + 32'd1) : i_cell.vel_x;
                r_va     <= w_vneg ? (~i_cell.vel_y + 32'd1) : i_cell.vel_y;
                r_width  <= i_cell.flow_width;
                r_len    <= i_cell.cell_length;
                r_ss     <= i_cell.susp_sediment;
                r_ssc    <= i_cell.susp_concentration;
                r_bl     <= i_cell.bed_sediment;
                r_blc    <= i_cell.bed_concentration;
                r_drain  <= w_drain;
                r_ndepth <= i_cell.depth;
                r_q      <= '0;
                r_sflux  <= '0;
            end
            gbo_pkg::OP_SQX:   r_p <= w_prod;
            gbo_pkg::OP_SQY: begin
                r_a <= r_p;
                r_p <= w_prod;
            end
            gbo_pkg::OP_SQSUM:    r_a <= r_a + r_p;
            gbo_pkg::OP_SQRT_GET: r_speed <= w_iq[31:0];
            gbo_pkg::OP_AREA:     r_p <= w_prod;
            gbo_pkg::OP_QLO, gbo_pkg::OP_RM2: begin
                r_a <= r_p;
                r_p <= w_prod;
            end
            gbo_pkg::OP_QHI, gbo_pkg::OP_RM3: begin
                r_b <= r_p;
                r_p <= w_prod;
            end
            gbo_pkg::OP_QSUM:  r_q <= w_hsat;
            gbo_pkg::OP_DROPM: r_p <= w_prod;
            gbo_pkg::OP_DROP_GET:
                r_ndepth <= (w_iq >= {32'b0, r_depth}) ? '0 : (r_depth - w_iq[31:0]);
            gbo_pkg::OP_RM1: r_p <= w_prod;
            gbo_pkg::OP_RM4: r_rmv <= w_hsat;
            gbo_pkg::OP_RM5: begin
                r_ds <= w_take;
                if (i_cmd.phase) begin
                    r_bl <= r_bl - w_take;
                end else begin
                    r_ss <= r_ss - w_take;
                end
            end
            gbo_pkg::OP_FDIV_GET:
                r_sflux <= w_fsum[32] ? gbo_pkg::MAX32 : w_fsum[31:0];
            default: ;
        endcase
    end

    // Running totals per sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wtot <= '0;
            r_stot <= '0;
        end else begin
            case (i_cmd.op)
                gbo_pkg::OP_LOAD: begin
                    if (i_cell.first_of_sweep) begin
                        r_wtot <= '0;
                        r_stot <= '0;
                    end
                end
                gbo_pkg::OP_DROP_GET:
                    r_wtot <= w_wsum[48] ? gbo_pkg::MAX48 : w_wsum[47:0];
                gbo_pkg::OP_STOT:
                    r_stot <= w_ssum[48] ? gbo_pkg::MAX48 : w_ssum[47:0];
                default: ;
            endcase
        end
    end

    assign o_stat.drain        = r_drain;
    assign o_stat.erosion_on   = i_erosion_on;
    assign o_stat.two_phase_on = i_two_phase_on;
    assign o_stat.ts_zero      = (i_time_step == '0);
    assign o_stat.iter_done    = w_idone;

    assign o_res.new_depth           = r_ndepth;
    assign o_res.outflowing          = r_drain;
    assign o_res.cell_outflow        = r_q;
    assign o_res.new_susp_sediment   = r_ss;
    assign o_res.new_bed_sediment    = r_bl;
    assign o_res.cell_sediment_flux  = r_sflux;
    assign o_res.total_outflow       = r_wtot;
    assign o_res.total_sediment_flux = r_stot;

    a_depth_not_raised: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == gbo_pkg::OP_DROP_GET |=> r_ndepth <= r_depth)
        else $error("drainage raised the depth");
    a_stock_not_raised: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == gbo_pkg::OP_RM5 && !i_cmd.phase |=> r_ss <= $past(r_ss))
        else $error("suspended stock grew");
    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == gbo_pkg::OP_DROP_GET |=> r_wtot >= $past(r_wtot))
        else $error("water total decreased");

endmodule

// ===== rtl/gbo_ctrl.sv =====
// Controller: one-hot sequencer that steps the datapath through one cell.
module gbo_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_free,
    input  gbo_pkg::t_stat  i_stat,
    output logic            o_in_ready,
    output logic            o_out_load,
    output gbo_pkg::t_cmd   o_cmd
);

    typedef enum logic [25:0] {
        S_IDLE      = 26'h0000001,
        S_DECIDE    = 26'h0000002,
        S_SQX       = 26'h0000004,
        S_SQY       = 26'h0000008,
        S_SQSUM     = 26'h0000010,
        S_SQRT_GO   = 26'h0000020,
        S_SQRT_WAIT = 26'h0000040,
        S_SQRT_GET  = 26'h0000080,
        S_AREA      = 26'h0000100,
        S_QLO       = 26'h0000200,
        S_QHI       = 26'h0000400,
        S_QSUM      = 26'h0000800,
        S_DROPM     = 26'h0001000,
        S_DROP_GO   = 26'h0002000,
        S_DROP_WAIT = 26'h0004000,
        S_DROP_GET  = 26'h0008000,
        S_RM1       = 26'h0010000,
        S_RM2       = 26'h0020000,
        S_RM3       = 26'h0040000,
        S_RM4       = 26'h0080000,
        S_RM5       = 26'h0100000,
        S_FDIV_GO   = 26'h0200000,
        S_FDIV_WAIT = 26'h0400000,
        S_FDIV_GET  = 26'h0800000,
        S_STOT      = 26'h1000000,
        S_FIN       = 26'h2000000
    } t_state;

    t_state r_state, n_state;
    logic   r_phase, n_phase;

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        o_cmd.op   = gbo_pkg::OP_NONE;
        o_cmd.phase = r_phase;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = gbo_pkg::OP_LOAD;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE:    n_state = i_stat.drain ? S_SQX : S_FIN;
            S_SQX:       begin o_cmd.op = gbo_pkg::OP_SQX;     n_state = S_SQY;     end
            S_SQY:       begin o_cmd.op = gbo_pkg::OP_SQY;     n_state = S_SQSUM;   end
            S_SQSUM:     begin o_cmd.op = gbo_pkg::OP_SQSUM;   n_state = S_SQRT_GO; end
            S_SQRT_GO:   begin o_cmd.op = gbo_pkg::OP_SQRT_GO; n_state = S_SQRT_WAIT; end
            S_SQRT_WAIT: if (i_stat.iter_done) n_state = S_SQRT_GET;
            S_SQRT_GET:  begin o_cmd.op = gbo_pkg::OP_SQRT_GET; n_state = S_AREA; end
            S_AREA:      begin o_cmd.op = gbo_pkg::OP_AREA;    n_state = S_QLO;     end
            S_QLO:       begin o_cmd.op = gbo_pkg::OP_QLO;     n_state = S_QHI;     end
            S_QHI:       begin o_cmd.op = gbo_pkg::OP_QHI;     n_state = S_QSUM;    end
            S_QSUM:      begin o_cmd.op = gbo_pkg::OP_QSUM;    n_state = S_DROPM;   end
            S_DROPM:     begin o_cmd.op = gbo_pkg::OP_DROPM;   n_state = S_DROP_GO; end
            S_DROP_GO:   begin o_cmd.op = gbo_pkg::OP_DROP_GO; n_state = S_DROP_WAIT; end
            S_DROP_WAIT: if (i_stat.iter_done) n_state = S_DROP_GET;
            S_DROP_GET: begin
                o_cmd.op = gbo_pkg::OP_DROP_GET;
                n_phase  = 1'b0;
                if (!i_stat.erosion_on) begin
                    n_state = S_FIN;
                end else if (i_stat.ts_zero) begin
                    n_state = S_STOT;
                end else begin
                    n_state = S_RM1;
                end
            end
            S_RM1:       begin o_cmd.op = gbo_pkg::OP_RM1;     n_state = S_RM2;     end
            S_RM2:       begin o_cmd.op = gbo_pkg::OP_RM2;     n_state = S_RM3;     end
            S_RM3:       begin o_cmd.op = gbo_pkg::OP_RM3;     n_state = S_RM4;     end
            S_RM4:       begin o_cmd.op = gbo_pkg::OP_RM4;     n_state = S_RM5;     end
            S_RM5:       begin o_cmd.op = gbo_pkg::OP_RM5;     n_state = S_FDIV_GO; end
            S_FDIV_GO:   begin o_cmd.op = gbo_pkg::OP_FDIV_GO; n_state = S_FDIV_WAIT; end
            S_FDIV_WAIT: if (i_stat.iter_done) n_state = S_FDIV_GET;
            S_FDIV_GET: begin
                o_cmd.op = gbo_pkg::OP_FDIV_GET;
                if (!r_phase && i_stat.two_phase_on) begin
                    n_phase = 1'b1;
                    n_state = S_RM1;
                end else begin
                    n_state = S_STOT;
                end
            end
            S_STOT: begin
                o_cmd.op = gbo_pkg::OP_STOT;
                n_phase  = 1'b0;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    a_wait_leaves_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DROP_WAIT && i_stat.iter_done |=> r_state == S_DROP_GET)
        else $error("divide result not taken");
    a_bed_only_two_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> i_stat.two_phase_on && i_stat.erosion_on)
        else $error("bed phase without two-phase mode");
    a_load_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |=> r_state == S_IDLE) else $error("result load outside finish");

endmodule
